[sv/svpwm_pkg.sv]
`default_nettype none
package svpwm_pkg;

   localparam int VOLT_FRAC_BITS_DEF = 14;
   localparam int PERIOD_BITS_DEF    = 16;

   localparam int IN_W       = 16;
   localparam int DUTY_W     = 16;
   localparam int SEC_W      = 3;
   localparam int SQ_W       = 32;
   localparam int VW         = 17;   // working width of scaled voltages
   localparam int RW         = 15;   // reciprocal root bits, Q0.15
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_TIMER_PERIOD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SWAP_AC      = 1'd1;

   localparam logic [DUTY_W-1:0] PERIOD_RESET = 16'd42500;

   localparam logic [15:0] K_SQRT3_2     = 16'd28378;
   localparam logic [15:0] K_INV_SQRT3   = 16'd18919;
   localparam logic [15:0] K_2_INV_SQRT3 = 16'd37837;

   localparam logic [SEC_W-1:0] SEC_1 = 3'd0;
   localparam logic [SEC_W-1:0] SEC_2 = 3'd1;
   localparam logic [SEC_W-1:0] SEC_3 = 3'd2;
   localparam logic [SEC_W-1:0] SEC_4 = 3'd3;
   localparam logic [SEC_W-1:0] SEC_5 = 3'd4;
   localparam logic [SEC_W-1:0] SEC_6 = 3'd5;

   typedef struct packed {
      logic signed [IN_W-1:0] u_alpha;
      logic signed [IN_W-1:0] u_beta;
      logic [SQ_W-1:0]        mag_sq;
      logic                   scale;
   } svpwm_vec_type;

   typedef struct packed {
      logic [DUTY_W-1:0] duty_ch1;
      logic [DUTY_W-1:0] duty_ch2;
      logic [DUTY_W-1:0] duty_ch3;
      logic [SEC_W-1:0]  sector_index;
   } svpwm_rsp_type;

   // x * c / 2^15, truncated toward zero
   function automatic logic signed [VW-1:0] mul_q15(input logic signed [VW-1:0] x,
                                                    input logic [15:0] c);
      logic [VW-1:0]    mag;
      logic [VW+15:0]   prod;
      logic [VW-1:0]    res;
      mag  = x[VW-1] ? VW'(-x) : VW'(x);
      prod = (VW+16)'(mag) * (VW+16)'(c);
      res  = prod[VW+14:15];
      return x[VW-1] ? -$signed(res) : $signed(res);
   endfunction

endpackage
`default_nettype wire

[sv/space_vector_pwm_duty_top.sv]
// Throughput: one request per cycle; the pipeline holds as a whole only while a
// finished result waits and the result queue is full.
// Reciprocal root takes 15 stages, one bit each; then 3 multiply, 1 sector, 2 duty stages.
// Reset is synchronous, active high: queues and pipeline flush, timer_period
// returns to 42500 and the phase A/C swap is cleared.
`default_nettype none
module space_vector_pwm_duty_top
   import svpwm_pkg::*;
#(
   parameter int VOLT_FRAC_BITS = VOLT_FRAC_BITS_DEF,
   parameter int PERIOD_BITS    = PERIOD_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire logic signed [IN_W-1:0] req_u_alpha,
   input  wire logic signed [IN_W-1:0] req_u_beta,
   output logic                       full,
   output logic                       empty,
   input  wire logic                  pop,
   output logic [DUTY_W-1:0]          rsp_duty_ch1,
   output logic [DUTY_W-1:0]          rsp_duty_ch2,
   output logic [DUTY_W-1:0]          rsp_duty_ch3,
   output logic [SEC_W-1:0]           rsp_sector_index,
   input  wire logic                  csr_wen,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [DUTY_W-1:0] PERIOD_MASK = (PERIOD_BITS >= DUTY_W) ? '1 :
                                               DUTY_W'((32'd1 << PERIOD_BITS) - 32'd1);
   localparam int VEC_W = $bits(svpwm_vec_type);
   localparam int RSP_W = $bits(svpwm_rsp_type);

   logic [DUTY_W-1:0] period_ff;
   logic              reverse_ff;

   logic              mq_push, mq_full, mq_pop, mq_empty;
   svpwm_vec_type     mq_wr_data;
   logic [VEC_W-1:0]  mq_rd_vec;
   logic              oq_push, oq_full;
   svpwm_rsp_type     oq_wr_data, rsp;
   logic [RSP_W-1:0]  oq_rd_vec;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= PERIOD_RESET;
         reverse_ff <= 1'b0;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_TIMER_PERIOD: period_ff  <= csr_wdata & PERIOD_MASK;
            CSR_SWAP_AC:      reverse_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   svpwm_front #(
      .VOLT_FRAC_BITS(VOLT_FRAC_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .u_alpha (req_u_alpha),
      .u_beta  (req_u_beta),
      .full    (full),
      .q_push  (mq_push),
      .q_data  (mq_wr_data),
      .q_full  (mq_full)
   );

   svpwm_fifo #(
      .WIDTH(VEC_W),
      .DEPTH(2)
   ) u_midq (
      .clock     (clock),
      .reset     (reset),
      .push      (mq_push),
      .push_data (mq_wr_data),
      .full      (mq_full),
      .pop       (mq_pop),
      .pop_data  (mq_rd_vec),
      .empty     (mq_empty)
   );

   svpwm_back #(
      .VOLT_FRAC_BITS(VOLT_FRAC_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (mq_empty),
      .q_data       (svpwm_vec_type'(mq_rd_vec)),
      .q_pop        (mq_pop),
      .o_full       (oq_full),
      .o_push       (oq_push),
      .o_data       (oq_wr_data),
      .timer_period (period_ff),
      .swap_ac      (reverse_ff)
   );

   svpwm_fifo #(
      .WIDTH(RSP_W),
      .DEPTH(2)
   ) u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (oq_push),
      .push_data (oq_wr_data),
      .full      (oq_full),
      .pop       (pop),
      .pop_data  (oq_rd_vec),
      .empty     (empty)
   );

   assign rsp              = svpwm_rsp_type'(oq_rd_vec);
   assign rsp_duty_ch1     = rsp.duty_ch1;
   assign rsp_duty_ch2     = rsp.duty_ch2;
   assign rsp_duty_ch3     = rsp.duty_ch3;
   assign rsp_sector_index = rsp.sector_index;

endmodule
`default_nettype wire

[sv/svpwm_fifo.sv]
`default_nettype none
module svpwm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

[sv/svpwm_front.sv]
`default_nettype none
module svpwm_front
   import svpwm_pkg::*;
#(
   parameter int VOLT_FRAC_BITS = VOLT_FRAC_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire logic signed [IN_W-1:0] u_alpha,
   input  wire logic signed [IN_W-1:0] u_beta,
   output logic                        full,
   output logic                        q_push,
   output svpwm_vec_type               q_data,
   input  wire logic                   q_full
);

   localparam int LIM_W = (2 * VOLT_FRAC_BITS + 2 > SQ_W + 1) ?
                          2 * VOLT_FRAC_BITS + 2 : SQ_W + 1;
   localparam logic [LIM_W-1:0] UNIT_SQ = LIM_W'(1) << (2 * VOLT_FRAC_BITS);

   logic                   vld_ff, vld_in;
   logic signed [IN_W-1:0] a_ff, b_ff;
   logic [SQ_W-1:0]        aa_ff, bb_ff;
   logic [SQ_W-1:0]        aa_in, bb_in;
   logic [SQ_W-1:0]        mag_sq;
   logic                   accept;

   assign full   = vld_ff && q_full;
   assign accept = push && !full;
   assign q_push = vld_ff && !q_full;

   always_comb begin
      aa_in  = $unsigned(SQ_W'(u_alpha) * SQ_W'(u_alpha));
      bb_in  = $unsigned(SQ_W'(u_beta) * SQ_W'(u_beta));
      vld_in = accept ? 1'b1 : (q_push ? 1'b0 : vld_ff);
      mag_sq = aa_ff + bb_ff;
      q_data.u_alpha = a_ff;
      q_data.u_beta  = b_ff;
      q_data.mag_sq  = mag_sq;
      // only strictly above unit magnitude gets pulled back
      q_data.scale   = LIM_W'(mag_sq) > UNIT_SQ;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_ff  <= u_alpha;
         b_ff  <= u_beta;
         aa_ff <= aa_in;
         bb_ff <= bb_in;
      end
   end

endmodule
`default_nettype wire

[sv/svpwm_back.sv]
`default_nettype none
module svpwm_back
   import svpwm_pkg::*;
#(
   parameter int VOLT_FRAC_BITS = VOLT_FRAC_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_empty,
   input  wire svpwm_vec_type     q_data,
   output logic                   q_pop,
   input  wire logic              o_full,
   output logic                   o_push,
   output svpwm_rsp_type          o_data,
   input  wire logic [DUTY_W-1:0] timer_period,
   input  wire logic              swap_ac
);

   localparam int F    = VOLT_FRAC_BITS;
   localparam int TW   = (31 + 2 * F > 64) ? 31 + 2 * F : 64;
   localparam int RSW  = RW + SQ_W;
   localparam int NW   = ((F + 2 > 20) ? F + 2 : 20) + 1;
   localparam int PRW  = NW - 1 + DUTY_W;
   localparam int LAST = RW + 6;
   localparam logic [TW-1:0]        RLIM  = TW'(1) << (30 + 2 * F);
   localparam logic signed [NW-1:0] ONE_N = NW'(1) << F;

   logic en;
   logic vld_ff [0:LAST];

   // reciprocal root stages: stage j settles bit RW-j
   logic signed [IN_W-1:0] a_ff  [0:RW];
   logic signed [IN_W-1:0] b_ff  [0:RW];
   logic [SQ_W-1:0]        s_ff  [0:RW];
   logic                   sc_ff [0:RW];
   logic [TW-1:0]          pw_ff [0:RW];   // r*r*s
   logic [RSW-1:0]         rs_ff [0:RW];   // r*s
   logic [RW-1:0]          r_ff  [0:RW];
   logic [TW-1:0]          trial_in [1:RW];
   logic                   take_in  [1:RW];
   logic [TW-1:0]          pw_in    [1:RW];
   logic [RSW-1:0]         rs_in    [1:RW];
   logic [RW-1:0]          r_in     [1:RW];

   logic signed [VW-1:0] a1_ff, b1_ff, a1_in, b1_in;
   logic signed [VW-1:0] a2_ff, b2_ff, a2_in, b2_in;
   logic signed [VW-1:0] a3_ff, b3_ff, p_ff, q_ff, p_in, q_in;
   logic signed [VW:0]   a_x, p_x, q_x, ap_c, mp_c, x_c, y_c;
   logic signed [VW+1:0] sum_c, dif_c;
   logic signed [NW-1:0] sum_n, dif_n;
   logic [SEC_W-1:0]     sec_in, sec4_ff, sec5_ff;
   logic signed [NW-1:0] na_in, nb_in, nc_in, na_ff, nb_ff, nc_ff;
   logic                 pa_ff, pb_ff, pc_ff;
   logic [PRW-1:0]       pra_ff, prb_ff, prc_ff, pra_in, prb_in, prc_in;
   logic [PRW-1:0]       va, vb, vc;
   logic [DUTY_W-1:0]    da, db, dc;
   svpwm_rsp_type        rsp_ff, rsp_in;

   assign en     = !(vld_ff[LAST] && o_full);
   assign q_pop  = en && !q_empty;
   assign o_push = vld_ff[LAST] && !o_full;
   assign o_data = rsp_ff;

   // largest r with r*r*s <= 2^(30+2F), one bit per stage
   always_comb begin
      for (int j = 1; j <= RW; j++) begin
         trial_in[j] = pw_ff[j-1] + (TW'(rs_ff[j-1]) << (RW + 1 - j))
                       + (TW'(s_ff[j-1]) << (2 * (RW - j)));
         take_in[j]  = (trial_in[j] <= RLIM);
         pw_in[j]    = take_in[j] ? trial_in[j] : pw_ff[j-1];
         rs_in[j]    = take_in[j] ? rs_ff[j-1] + (RSW'(s_ff[j-1]) << (RW - j))
                                  : rs_ff[j-1];
         r_in[j]     = take_in[j] ? (r_ff[j-1] | (RW'(1) << (RW - j))) : r_ff[j-1];
      end
   end

   always_comb begin
      if (sc_ff[RW]) begin
         a1_in = mul_q15(VW'(a_ff[RW]), 16'(r_ff[RW]));
         b1_in = mul_q15(VW'(b_ff[RW]), 16'(r_ff[RW]));
      end else begin
         a1_in = VW'(a_ff[RW]);
         b1_in = VW'(b_ff[RW]);
      end
      a2_in = mul_q15(a1_ff, K_SQRT3_2);
      b2_in = mul_q15(b1_ff, K_SQRT3_2);
      p_in  = mul_q15(b2_ff, K_INV_SQRT3);
      q_in  = mul_q15(b2_ff, K_2_INV_SQRT3);
   end

   // sector and the three compare numerators
   always_comb begin
      a_x  = (VW+1)'(a3_ff);
      p_x  = (VW+1)'(p_ff);
      q_x  = (VW+1)'(q_ff);
      ap_c = a_x + p_x;
      mp_c = p_x - a_x;
      if (!b3_ff[VW-1]) begin
         if (p_x < a_x)       sec_in = SEC_1;
         else if (-p_x < a_x) sec_in = SEC_2;
         else                 sec_in = SEC_3;
      end else begin
         if (p_x > a_x)       sec_in = SEC_4;
         else if (-p_x > a_x) sec_in = SEC_5;
         else                 sec_in = SEC_6;
      end
      case (sec_in)
         SEC_1: begin x_c = -mp_c; y_c = q_x;   end
         SEC_2: begin x_c = ap_c;  y_c = mp_c;  end
         SEC_3: begin x_c = q_x;   y_c = -ap_c; end
         SEC_4: begin x_c = mp_c;  y_c = -q_x;  end
         SEC_5: begin x_c = -ap_c; y_c = -mp_c; end
         default: begin x_c = -q_x; y_c = ap_c; end
      endcase
      sum_c = (VW+2)'(x_c) + (VW+2)'(y_c);
      dif_c = (VW+2)'(x_c) - (VW+2)'(y_c);
      sum_n = NW'(sum_c);
      dif_n = NW'(dif_c);
      case (sec_in)
         SEC_1: begin
            na_in = ONE_N + sum_n; nb_in = ONE_N - dif_n; nc_in = ONE_N - sum_n;
         end
         SEC_2: begin
            na_in = ONE_N + dif_n; nb_in = ONE_N + sum_n; nc_in = ONE_N - sum_n;
         end
         SEC_3: begin
            na_in = ONE_N - sum_n; nb_in = ONE_N + sum_n; nc_in = ONE_N - dif_n;
         end
         SEC_4: begin
            na_in = ONE_N - sum_n; nb_in = ONE_N + dif_n; nc_in = ONE_N + sum_n;
         end
         SEC_5: begin
            na_in = ONE_N - dif_n; nb_in = ONE_N - sum_n; nc_in = ONE_N + sum_n;
         end
         default: begin
            na_in = ONE_N + sum_n; nb_in = ONE_N - sum_n; nc_in = ONE_N + dif_n;
         end
      endcase
   end

   always_comb begin
      pra_in = PRW'(na_ff[NW-2:0]) * PRW'(timer_period);
      prb_in = PRW'(nb_ff[NW-2:0]) * PRW'(timer_period);
      prc_in = PRW'(nc_ff[NW-2:0]) * PRW'(timer_period);
      va = pra_ff >> (F + 1);
      vb = prb_ff >> (F + 1);
      vc = prc_ff >> (F + 1);
      da = !pa_ff ? '0 : ((va > PRW'(timer_period)) ? timer_period : va[DUTY_W-1:0]);
      db = !pb_ff ? '0 : ((vb > PRW'(timer_period)) ? timer_period : vb[DUTY_W-1:0]);
      dc = !pc_ff ? '0 : ((vc > PRW'(timer_period)) ? timer_period : vc[DUTY_W-1:0]);
      rsp_in.duty_ch1     = swap_ac ? dc : da;
      rsp_in.duty_ch2     = db;
      rsp_in.duty_ch3     = swap_ac ? da : dc;
      rsp_in.sector_index = sec5_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= LAST; j++) begin
            vld_ff[j] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= !q_empty;
         for (int j = 1; j <= LAST; j++) begin
            vld_ff[j] <= vld_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff[0]  <= q_data.u_alpha;
         b_ff[0]  <= q_data.u_beta;
         s_ff[0]  <= q_data.mag_sq;
         sc_ff[0] <= q_data.scale;
         pw_ff[0] <= '0;
         rs_ff[0] <= '0;
         r_ff[0]  <= '0;
         for (int j = 1; j <= RW; j++) begin
            a_ff[j]  <= a_ff[j-1];
            b_ff[j]  <= b_ff[j-1];
            s_ff[j]  <= s_ff[j-1];
            sc_ff[j] <= sc_ff[j-1];
            pw_ff[j] <= pw_in[j];
            rs_ff[j] <= rs_in[j];
            r_ff[j]  <= r_in[j];
         end
         a1_ff   <= a1_in;
         b1_ff   <= b1_in;
         a2_ff   <= a2_in;
         b2_ff   <= b2_in;
         a3_ff   <= a2_ff;
         b3_ff   <= b2_ff;
         p_ff    <= p_in;
         q_ff    <= q_in;
         sec4_ff <= sec_in;
         na_ff   <= na_in;
         nb_ff   <= nb_in;
         nc_ff   <= nc_in;
         sec5_ff <= sec4_ff;
         pa_ff   <= !na_ff[NW-1] && (na_ff != '0);
         pb_ff   <= !nb_ff[NW-1] && (nb_ff != '0);
         pc_ff   <= !nc_ff[NW-1] && (nc_ff != '0);
         pra_ff  <= pra_in;
         prb_ff  <= prb_in;
         prc_ff  <= prc_in;
         rsp_ff  <= rsp_in;
      end
   end

endmodule
`default_nettype wire

[sv/svpwm_chk.sv]
`default_nettype none
module svpwm_chk
   import svpwm_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             push,
   input wire logic             full,
   input wire logic             pop,
   input wire logic             empty,
   input wire logic [SEC_W-1:0] rsp_sector_index
);

   // requests accepted and not yet popped
   logic [5:0] outstanding_ff, outstanding_in;

   assign outstanding_in = outstanding_ff + 6'(push && !full) - 6'(pop && !empty);

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> empty)
      else $error("result queue not empty after reset");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      !empty |-> outstanding_ff != '0)
      else $error("result shown with no request outstanding");

   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff == '0 |-> !full)
      else $error("full with nothing in flight");

   a_sector_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> rsp_sector_index <= SEC_6)
      else $error("sector out of range");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty)
      else $error("waiting result dropped");

endmodule

bind space_vector_pwm_duty_top svpwm_chk u_chk (
   .clock            (clock),
   .reset            (reset),
   .push             (push),
   .full             (full),
   .pop              (pop),
   .empty            (empty),
   .rsp_sector_index (rsp_sector_index)
);
`default_nettype wire
